### rtl/mandelbrot_escape_time_macros.svh
// Assertion macros shared by the escape-time block.
`ifndef MANDELBROT_ESCAPE_TIME_MACROS_SVH
`define MANDELBROT_ESCAPE_TIME_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define MBE_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mbe: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define MBE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("mbe: next-cycle check failed");

`endif

### rtl/mbe_pkg.sv
// Shared widths, register indexes and sequencer states of the escape-time block.
`timescale 1ns / 1ps

package mbe_pkg;

   localparam int unsigned COORD_W    = 32;
   localparam int unsigned COUNT_W    = 16;
   localparam int unsigned PEN_W      = 5;
   localparam int unsigned ESC_W      = 7;
   localparam int unsigned CSR_IDX_W  = 2;
   localparam int unsigned CSR_DATA_W = 16;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ITER_LIMIT = 2'd0,
      CSR_ESC_LIMIT  = 2'd1
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SQ_X,
      ST_SQ_Y,
      ST_SQ_XY,
      ST_UPDATE,
      ST_FINISH
   } mbe_state_type;

endpackage

### rtl/mbe_channel_if.sv
// Valid/ready channel interfaces for point beats and result beats.
`timescale 1ns / 1ps

interface mbe_req_if
   import mbe_pkg::*;
();
   logic                      valid;
   logic                      ready;
   logic signed [COORD_W-1:0] point_real;
   logic signed [COORD_W-1:0] point_imag;

   modport source (output valid, output point_real, output point_imag, input ready);
   modport sink   (input valid, input point_real, input point_imag, output ready);
endinterface

interface mbe_rsp_if
   import mbe_pkg::*;
();
   logic               valid;
   logic               ready;
   logic [COUNT_W-1:0] iteration_count;
   logic               inside_set;
   logic [PEN_W-1:0]   pen_index;

   modport source (output valid, output iteration_count, output inside_set,
                   output pen_index, input ready);
   modport sink   (input valid, input iteration_count, input inside_set,
                   input pen_index, output ready);
endinterface

### rtl/mandelbrot_escape_time.sv
// Escape-time evaluator for one complex point, on one shared 32x32 multiplier.
`timescale 1ns / 1ps
//
//  channel   direction  handshake          beat contents
//  --------  ---------  -----------------  ------------------------------------------
//  req_chan  in         valid / ready      point_real, point_imag (signed Q8.24)
//  rsp_chan  out        valid / ready      iteration_count, inside_set, pen_index
//  csr_*     in         csr_wr_en only     csr_index (0 limit, 1 escape), csr_wdata
//
//  Each iteration steps through x*x, y*y, x*y on the one multiplier, then the update.
//  A point that stays inside runs N such rounds from accept to result, N the limit
//  (none for a zero limit); a point that escapes after N updates runs one round more, the
//  last round being the failed escape test. Either may then wait for the result register to drain.
//  Reset (synchronous, active high) empties the sequencer and the result register and
//  loads the limits with 50 and 16.
//  req_chan is ready only while the sequencer is idle; a result left untaken holds in
//  the output register and does not stop the next point being accepted.
`include "mandelbrot_escape_time_macros.svh"

module mandelbrot_escape_time
   import mbe_pkg::*;
#(
   parameter int unsigned PEN_BITS = 5
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   mbe_req_if.sink               req_chan,
   mbe_rsp_if.source             rsp_chan
);

   // Configuration registers
   logic [COUNT_W-1:0] iter_limit_ff;
   logic [ESC_W-1:0]   esc_limit_ff;

   // Sequencer and datapath registers
   mbe_state_type             state_ff, state_in;
   logic signed [COORD_W-1:0] cr_ff, cr_in;
   logic signed [COORD_W-1:0] ci_ff, ci_in;
   logic signed [COORD_W-1:0] x_ff, x_in;
   logic signed [COORD_W-1:0] y_ff, y_in;
   logic signed [63:0]        xx_ff, xx_in;
   logic signed [63:0]        yy_ff, yy_in;
   logic signed [63:0]        xy_ff, xy_in;
   logic signed [39:0]        dsh_ff, dsh_in;
   logic                      esc_ff, esc_in;
   logic [COUNT_W-1:0]        k_ff, k_in;
   logic                      inside_ff, inside_in;

   // Result register
   logic               rsp_valid_ff, rsp_valid_in;
   logic [COUNT_W-1:0] rsp_count_ff, rsp_count_in;
   logic               rsp_inside_ff, rsp_inside_in;
   logic [PEN_W-1:0]   rsp_pen_ff, rsp_pen_in;

   // Shared multiplier
   logic signed [COORD_W-1:0] mul_a, mul_b;
   logic signed [63:0]        prod;

   // Combinational helpers
   logic [64:0]        mag;
   logic [64:0]        bound;
   logic signed [63:0] diff;
   logic signed [41:0] nx_sum, ny_sum;
   logic [COUNT_W-1:0] k_next;
   logic [PEN_W-1:0]   pen_raw;
   logic               rsp_free;

   // Clamp a 42-bit sum to the signed 32-bit range.
   function automatic logic signed [COORD_W-1:0] sat32(input logic signed [41:0] v);
      logic all_same;
      all_same = (v[41:31] == {11{v[41]}});
      if (all_same) begin
         return v[31:0];
      end else if (v[41]) begin
         return {1'b1, {(COORD_W-1){1'b0}}};
      end else begin
         return {1'b0, {(COORD_W-1){1'b1}}};
      end
   endfunction

   // Configuration writes; indexes beyond the list are dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         iter_limit_ff <= COUNT_W'(50);
         esc_limit_ff  <= ESC_W'(16);
      end else if (csr_wr_en) begin
         if (csr_index == CSR_ITER_LIMIT) begin
            iter_limit_ff <= csr_wdata[COUNT_W-1:0];
         end
         if (csr_index == CSR_ESC_LIMIT) begin
            esc_limit_ff <= csr_wdata[ESC_W-1:0];
         end
      end
   end

   // Multiplier: operands set by the sequencer step; the square steps register the product.
   assign prod = mul_a * mul_b;

   // Escape test on |z|^2 against limit << 48, both squares non-negative.
   assign mag   = {1'b0, xx_ff} + {1'b0, yy_ff};
   assign bound = {10'd0, esc_limit_ff, 48'd0};

   // Real update prepared in the x*y step, ahead of the update: floor((xx - yy) / 2^24).
   assign diff = xx_ff - yy_ff;

   // New z, each part floored, offset by c and clamped.
   assign nx_sum = {{2{dsh_ff[39]}}, dsh_ff} + {{10{cr_ff[COORD_W-1]}}, cr_ff};
   assign ny_sum = {xy_ff[63], xy_ff[63:23]} + {{10{ci_ff[COORD_W-1]}}, ci_ff};

   // k stays below the limit while iterating, so the increment cannot wrap.
   assign k_next = k_ff + COUNT_W'(1);

   // Pen: low PEN_BITS bits of the count, kept to the field width.
   always_comb begin
      for (int i = 0; i < PEN_W; i++) begin
         pen_raw[i] = (i < PEN_BITS) ? k_ff[i] : 1'b0;
      end
   end

   assign rsp_free = !rsp_valid_ff || rsp_chan.ready;

   // Sequencer: next state, multiplier steering and datapath loads.
   always_comb begin
      state_in      = state_ff;
      cr_in         = cr_ff;
      ci_in         = ci_ff;
      x_in          = x_ff;
      y_in          = y_ff;
      xx_in         = xx_ff;
      yy_in         = yy_ff;
      xy_in         = xy_ff;
      dsh_in        = dsh_ff;
      esc_in        = esc_ff;
      k_in          = k_ff;
      inside_in     = inside_ff;
      mul_a         = x_ff;
      mul_b         = x_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_count_in  = rsp_count_ff;
      rsp_inside_in = rsp_inside_ff;
      rsp_pen_in    = rsp_pen_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               cr_in     = req_chan.point_real;
               ci_in     = req_chan.point_imag;
               x_in      = req_chan.point_real;
               y_in      = req_chan.point_imag;
               k_in      = '0;
               inside_in = (iter_limit_ff == '0);
               state_in  = (iter_limit_ff == '0) ? ST_FINISH : ST_SQ_X;
            end
         end
         ST_SQ_X: begin
            mul_a    = x_ff;
            mul_b    = x_ff;
            xx_in    = prod;
            state_in = ST_SQ_Y;
         end
         ST_SQ_Y: begin
            mul_a    = y_ff;
            mul_b    = y_ff;
            yy_in    = prod;
            state_in = ST_SQ_XY;
         end
         ST_SQ_XY: begin
            mul_a    = x_ff;
            mul_b    = y_ff;
            xy_in    = prod;
            esc_in   = (mag > bound);
            dsh_in   = diff[63:24];
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            if (esc_ff) begin
               inside_in = 1'b0;
               state_in  = ST_FINISH;
            end else begin
               x_in = sat32(nx_sum);
               y_in = sat32(ny_sum);
               k_in = k_next;
               if (k_next == iter_limit_ff) begin
                  inside_in = 1'b1;
                  state_in  = ST_FINISH;
               end else begin
                  state_in = ST_SQ_X;
               end
            end
         end
         ST_FINISH: begin
            // Hold until the result register can take the beat.
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_count_in  = k_ff;
               rsp_inside_in = inside_ff;
               rsp_pen_in    = inside_ff ? PEN_W'(1) : pen_raw;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      cr_ff         <= cr_in;
      ci_ff         <= ci_in;
      x_ff          <= x_in;
      y_ff          <= y_in;
      xx_ff         <= xx_in;
      yy_ff         <= yy_in;
      xy_ff         <= xy_in;
      dsh_ff        <= dsh_in;
      esc_ff        <= esc_in;
      k_ff          <= k_in;
      inside_ff     <= inside_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_inside_ff <= rsp_inside_in;
      rsp_pen_ff    <= rsp_pen_in;
   end

   assign req_chan.ready           = (state_ff == ST_IDLE);
   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.iteration_count = rsp_count_ff;
   assign rsp_chan.inside_set      = rsp_inside_ff;
   assign rsp_chan.pen_index       = rsp_pen_ff;

   // Checks
   `MBE_ASSERT_NEXT(a_finish_loads_rsp, clock, reset,
      (state_ff == ST_FINISH) && !rsp_valid_ff, rsp_valid_ff && (state_ff == ST_IDLE))
   `MBE_ASSERT_NEXT(a_escape_ends_loop, clock, reset,
      (state_ff == ST_UPDATE) && esc_ff, state_ff == ST_FINISH)
   `MBE_ASSERT_NOW(a_count_in_range, clock, reset,
      state_ff != ST_IDLE, k_ff <= iter_limit_ff)
   `MBE_ASSERT_NOW(a_inside_result, clock, reset, rsp_valid_ff && rsp_inside_ff,
      (rsp_count_ff == iter_limit_ff) && (rsp_pen_ff == PEN_W'(1)))

endmodule

### dv/mbe_escape_check.sv
// Escape-time checker: predicts one result per accepted point and compares result beats.
`timescale 1ns / 1ps

module mbe_escape_check
   import mbe_pkg::*;
#(
   parameter int unsigned PEN_BITS = 5
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   mbe_req_if                    req_mon,
   mbe_rsp_if                    rsp_mon,
   output int unsigned           error_count,
   output int unsigned           pending_count
);

   localparam logic [COUNT_W-1:0] ITER_LIMIT_RESET = 16'd50;
   localparam logic [ESC_W-1:0]   ESC_LIMIT_RESET  = 7'd16;
   localparam longint             COORD_HI         = 64'sd2147483647;
   localparam longint             COORD_LO         = -64'sd2147483648;

   typedef struct packed {
      logic [COUNT_W-1:0] count;
      logic               in_set;
      logic [PEN_W-1:0]   pen;
   } pixel_result_type;

   logic [COUNT_W-1:0] iter_limit = ITER_LIMIT_RESET;
   logic [ESC_W-1:0]   esc_limit  = ESC_LIMIT_RESET;
   pixel_result_type   pixel_q[$];
   int unsigned        mismatches = 0;

   function automatic longint clamp_coord(input longint v);
      if (v > COORD_HI) return COORD_HI;
      if (v < COORD_LO) return COORD_LO;
      return v;
   endfunction

   // Iterate z = z*z + c from z = c until |z|^2 passes the bound or the limit is hit.
   function automatic pixel_result_type escape_time(input logic signed [COORD_W-1:0] c_re,
                                                    input logic signed [COORD_W-1:0] c_im,
                                                    input logic [COUNT_W-1:0] lim,
                                                    input logic [ESC_W-1:0] esc);
      longint                x, y, xx, yy, xy, cr, ci;
      longint unsigned       mag, bound;
      int unsigned           k;
      pixel_result_type      r;
      cr    = longint'(c_re);
      ci    = longint'(c_im);
      x     = cr;
      y     = ci;
      bound = 64'(esc) << 48;
      k     = 0;
      while (k < lim) begin
         xx  = x * x;
         yy  = y * y;
         mag = 64'(xx) + 64'(yy);
         if (mag > bound) break;
         xy = x * y;
         // arithmetic shift of a signed value rounds toward minus infinity
         x  = clamp_coord((( xx - yy) >>> 24) + cr);
         y  = clamp_coord((xy >>> 23) + ci);
         k++;
      end
      r.in_set = (k >= lim);
      r.count  = k[COUNT_W-1:0];
      r.pen    = r.in_set ? PEN_W'(1) : PEN_W'(k & ((32'd1 << PEN_BITS) - 1));
      return r;
   endfunction

   always @(posedge clock) begin
      pixel_result_type want;
      if (reset) begin
         iter_limit = ITER_LIMIT_RESET;
         esc_limit  = ESC_LIMIT_RESET;
         pixel_q.delete();
      end else begin
         // retire the result beat first so a beat with nothing waiting is caught
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (pixel_q.size() == 0) begin
               $display("%0t mbe: result beat with nothing expected: count %0d inside %0b pen %0d",
                        $time, rsp_mon.iteration_count, rsp_mon.inside_set, rsp_mon.pen_index);
               mismatches++;
            end else begin
               want = pixel_q.pop_front();
               if (rsp_mon.iteration_count !== want.count) begin
                  $display("%0t mbe: iteration_count expected %0d got %0d",
                           $time, want.count, rsp_mon.iteration_count);
                  mismatches++;
               end
               if (rsp_mon.inside_set !== want.in_set) begin
                  $display("%0t mbe: inside_set expected %0b got %0b",
                           $time, want.in_set, rsp_mon.inside_set);
                  mismatches++;
               end
               if (rsp_mon.pen_index !== want.pen) begin
                  $display("%0t mbe: pen_index expected %0d got %0d",
                           $time, want.pen, rsp_mon.pen_index);
                  mismatches++;
               end
            end
         end
         if (req_mon.valid && req_mon.ready)
            pixel_q.push_back(escape_time(req_mon.point_real, req_mon.point_imag,
                                          iter_limit, esc_limit));
         if (csr_wr_en) begin
            case (csr_index)
               CSR_ITER_LIMIT: iter_limit = csr_wdata[COUNT_W-1:0];
               CSR_ESC_LIMIT:  esc_limit  = csr_wdata[ESC_W-1:0];
               default: ;
            endcase
         end
      end
      error_count   <= mismatches;
      pending_count <= pixel_q.size();
   end

endmodule

### dv/tb_mandelbrot_escape_time.sv
// Testbench top: drives points and limits into the escape-time block and reports the verdict.
`timescale 1ns / 1ps

module tb_mandelbrot_escape_time;
   import mbe_pkg::*;

   localparam int unsigned PEN_BITS       = 5;
   localparam int unsigned STALL_MAX      = 6;
   // slowest point: an inside run at the largest limit; allow roughly four of those with no beat
   localparam int unsigned WATCHDOG_LIMIT = 1_100_000;
   localparam int unsigned TAIL_CYCLES    = 64;
   localparam int unsigned RANDOM_PHASES  = 12;
   localparam int unsigned PHASE_POINTS   = 56;
   // index with no register behind it; writes to it must change nothing
   localparam logic [CSR_IDX_W-1:0] CSR_IDX_SPARE = 2'd3;

   // Q8.24 constants
   localparam logic signed [COORD_W-1:0] Q_ZERO    = 32'sh0000_0000;
   localparam logic signed [COORD_W-1:0] Q_LSB     = 32'sh0000_0001;
   localparam logic signed [COORD_W-1:0] Q_QUARTER = 32'sh0040_0000;
   localparam logic signed [COORD_W-1:0] Q_HALF    = 32'sh0080_0000;
   localparam logic signed [COORD_W-1:0] Q_ONE     = 32'sh0100_0000;
   localparam logic signed [COORD_W-1:0] Q_SEVEN_9 = 32'sh07E6_6666;
   localparam logic signed [COORD_W-1:0] Q_ELEVEN  = 32'sh0B00_0000;
   localparam logic signed [COORD_W-1:0] Q_MAX     = 32'sh7FFF_FFFF;
   localparam logic signed [COORD_W-1:0] Q_MIN     = 32'sh8000_0000;

   logic                  clock;
   logic                  reset;
   logic                  csr_wr_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   // when set, both sides run flat out with no idling
   bit                    steady = 1'b0;
   int unsigned           error_count;
   int unsigned           pending_count;
   int unsigned           quiet_cycles = 0;

   mbe_req_if req_chan ();
   mbe_rsp_if rsp_chan ();

   mandelbrot_escape_time #(
      .PEN_BITS (PEN_BITS)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan)
   );

   mbe_escape_check #(
      .PEN_BITS (PEN_BITS)
   ) pixel_check (
      .clock         (clock),
      .reset         (reset),
      .csr_wr_en     (csr_wr_en),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .req_mon       (req_chan),
      .rsp_mon       (rsp_chan),
      .error_count   (error_count),
      .pending_count (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Offer one point beat after a random gap; return at the edge that accepts it.
   // Valid stays high across back-to-back beats so it is never lowered and raised
   // in the same step.
   task automatic send_point(input logic signed [COORD_W-1:0] re,
                             input logic signed [COORD_W-1:0] im);
      int unsigned gap;
      gap = steady ? 0 : $urandom_range(0, STALL_MAX);
      if (gap != 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid      <= 1'b1;
      req_chan.point_real <= re;
      req_chan.point_imag <= im;
      do @(posedge clock); while (!req_chan.ready);
   endtask

   // Drop valid, wait for every outstanding result, then write both limits and
   // poke the spare index. The first edge lets the checker see the last beat.
   task automatic load_limits(input logic [COUNT_W-1:0] lim, input logic [ESC_W-1:0] esc);
      logic [CSR_DATA_W-1:0] esc_word;
      req_chan.valid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
      // junk in the upper bits of the escape word must be dropped by the block
      esc_word              = CSR_DATA_W'($urandom);
      esc_word[ESC_W-1:0]   = esc;
      csr_wr_en <= 1'b1;
      csr_index <= CSR_ITER_LIMIT;
      csr_wdata <= lim;
      @(posedge clock);
      csr_index <= CSR_ESC_LIMIT;
      csr_wdata <= esc_word;
      @(posedge clock);
      csr_index <= CSR_IDX_SPARE;
      csr_wdata <= CSR_DATA_W'($urandom);
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // Mostly points around the set, some anywhere in the range, some within 255 LSBs of zero.
   function automatic logic signed [COORD_W-1:0] draw_coord(input bit imag_axis);
      logic signed [COORD_W-1:0] v;
      case ($urandom_range(0, 9))
         0: v = $urandom;
         1: begin
            v = $urandom_range(0, 255);
            if ($urandom_range(0, 1) != 0) v = -v;
         end
         default: begin
            if (imag_axis) v = $urandom_range(0, 32'h0300_0000) - 32'h0180_0000;
            else           v = $urandom_range(0, 32'h0300_0000) - 32'h0240_0000;
         end
      endcase
      return v;
   endfunction

   // Result side: hold ready low for a random stall before each beat, then take it.
   initial begin : result_sink
      int unsigned stall;
      rsp_chan.ready <= 1'b0;
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         stall = steady ? 0 : $urandom_range(0, STALL_MAX);
         if (stall != 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         do @(posedge clock); while (!rsp_chan.valid);
      end
   end

   // Watchdog: end the run if no beat moves on either channel for too long.
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         quiet_cycles <= 0;
      else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("tb_mandelbrot_escape_time: errors");
         $finish;
      end else
         quiet_cycles <= quiet_cycles + 1;
   end

   initial begin : stimulus
      logic [COUNT_W-1:0] lim;
      logic [ESC_W-1:0]   esc;

      reset               <= 1'b1;
      csr_wr_en           <= 1'b0;
      csr_index           <= CSR_ITER_LIMIT;
      csr_wdata           <= '0;
      req_chan.valid      <= 1'b0;
      req_chan.point_real <= Q_ZERO;
      req_chan.point_imag <= Q_ZERO;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Reset limits (50 iterations, bound 16): corners of the range and classic points.
      send_point(Q_ZERO, Q_ZERO);            // origin, never escapes
      send_point(Q_MAX, Q_MAX);              // escapes before the first update
      send_point(Q_MIN, Q_MIN);
      send_point(Q_MAX, Q_MIN);
      send_point(Q_MIN, Q_MAX);
      send_point(-2 * Q_ONE, Q_ZERO);        // left tip of the set, orbit pinned at 2
      send_point(Q_QUARTER, Q_ZERO);         // cusp, creeps towards one half
      send_point(-Q_ONE, Q_ZERO);            // orbit alternates between -1 and 0
      send_point(Q_ZERO, Q_ONE);             // i, lands on a cycle
      send_point(Q_LSB, -Q_LSB);             // negative products must round down, not to zero
      send_point(Q_HALF, Q_HALF);            // escapes after a few updates

      // Widest bound: z can get near 11 unescaped, so the update saturates both ways.
      load_limits(16'd40, 7'd127);
      send_point(Q_ELEVEN, Q_ZERO);          // real part clips high
      send_point(Q_SEVEN_9, -Q_SEVEN_9);     // imaginary part clips low
      send_point(Q_SEVEN_9, Q_SEVEN_9);      // imaginary part clips high
      send_point(-Q_ELEVEN, Q_ZERO);

      // Zero iteration limit: every point is inside with a count of zero.
      load_limits(16'd0, 7'd5);
      send_point(Q_ZERO, Q_ZERO);
      send_point(Q_MAX, Q_MIN);

      // Zero bound: anything but the origin escapes at once.
      load_limits(16'd20, 7'd0);
      send_point(Q_ZERO, Q_ZERO);
      send_point(Q_LSB, -Q_LSB);
      send_point(Q_QUARTER, Q_ZERO);

      // Largest limit: one full-length point, then two quick ones.
      load_limits(16'hFFFF, 7'd4);
      send_point(Q_ZERO, Q_ZERO);
      send_point(Q_MAX, Q_MAX);
      send_point(Q_HALF, Q_HALF);

      // Smallest non-zero settings: |c|^2 equal to the bound does not escape.
      load_limits(16'd1, 7'd1);
      send_point(Q_ONE, Q_ZERO);
      send_point(Q_ZERO, -Q_ONE - Q_LSB);

      // Random phases: fresh limits each time, mostly short limits to keep the run brisk.
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         case ($urandom_range(0, 7))
            0:       lim = 16'd1;
            1:       lim = COUNT_W'($urandom_range(2, 15));
            2:       lim = COUNT_W'($urandom_range(100, 200));
            default: lim = COUNT_W'($urandom_range(16, 99));
         endcase
         case ($urandom_range(0, 5))
            0:       esc = 7'd127;
            1:       esc = 7'd1;
            2:       esc = 7'd4;
            default: esc = ESC_W'($urandom_range(1, 127));
         endcase
         load_limits(lim, esc);
         steady = ($urandom_range(0, 3) == 0);
         repeat (PHASE_POINTS) send_point(draw_coord(1'b0), draw_coord(1'b1));
      end

      // Drain: wait for every result, then give stray beats a chance to show.
      req_chan.valid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
      repeat (TAIL_CYCLES) @(posedge clock);

      if (error_count == 0 && pending_count == 0)
         $display("tb_mandelbrot_escape_time: clean");
      else
         $display("tb_mandelbrot_escape_time: errors");
      $finish;
   end

endmodule

### sim.f
+incdir+rtl
rtl/mbe_pkg.sv
rtl/mbe_channel_if.sv
rtl/mandelbrot_escape_time.sv
dv/mbe_escape_check.sv
dv/tb_mandelbrot_escape_time.sv
